// ===== rtl/fwws_pkg.sv =====
// shared types and constants for the weighted window sum filter
`default_nettype none

package fwws_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int SUM_W     = 35;
    localparam int NUM_COEFS = 8;
    localparam int COEF_IDX_W = $clog2(NUM_COEFS);
    localparam int CFG_IDX_W = COEF_IDX_W + 1;
    localparam int Q_SHIFT   = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // load enables for the datapath stages
    typedef struct packed {
        logic prod_ld;
        logic sum_ld;
    } t_stage_en;

endpackage

`default_nettype wire

// ===== rtl/fwws_sample_if.sv =====
// sample channel: valid, ready and one input sample
`default_nettype none

interface fwws_sample_if;
    import fwws_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwws_result_if.sv =====
// result channel: valid, ready, weighted sum and warm-up flag
`default_nettype none

interface fwws_result_if;
    import fwws_pkg::*;

    logic valid;
    logic ready;
    t_sum weighted_sum;
    logic warming_up;

    modport source (output valid, output weighted_sum, output warming_up, input ready);
    modport sink   (input valid, input weighted_sum, input warming_up, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwws_dot.sv =====
// product lanes and adder tree for the filter window
`default_nettype none

module fwws_dot #(
    parameter int TAPS = 8
) (
    input  wire logic                i_clk,
    input  wire fwws_pkg::t_stage_en i_en,
    input  wire fwws_pkg::t_sample   i_win [TAPS],
    input  wire logic                i_warm,
    input  wire fwws_pkg::t_coef     i_coef [fwws_pkg::NUM_COEFS],
    output fwws_pkg::t_sum           o_sum,
    output logic                     o_warm
);
    import fwws_pkg::*;

    t_prod   r_prod [TAPS];
    logic    r_pwarm;
    t_sample r_psamp;
    t_sum    r_sum;
    logic    r_swarm;
    t_sum    n_sum;

    // one multiplier per tap, registered
    always_ff @(posedge i_clk) begin
        if (i_en.prod_ld) begin
            for (int j = 0; j < TAPS; j++) begin
                r_prod[j] <= t_prod'(i_win[j]) * t_prod'(i_coef[j]);
            end
            r_pwarm <= i_warm;
            r_psamp <= i_win[TAPS-1];
        end
    end

    // adder tree, or the newest sample moved to q15 scale during warm-up
    always_comb begin
        t_sum acc;
        acc = '0;
        for (int j = 0; j < TAPS; j++) begin
            acc = acc + SUM_W'(r_prod[j]);
        end
        if (r_pwarm) begin
            n_sum = {{(SUM_W-SAMPLE_W-Q_SHIFT){r_psamp[SAMPLE_W-1]}}, r_psamp,
                     {Q_SHIFT{1'b0}}};
        end else begin
            n_sum = acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_en.sum_ld) begin
            r_sum   <= n_sum;
            r_swarm <= r_pwarm;
        end
    end

    assign o_sum  = r_sum;
    assign o_warm = r_swarm;

endmodule

`default_nettype wire

// ===== rtl/fir_weighted_window_sum_core.sv =====
// FIR weighted window sum: top level with history, coefficients and pipeline control
//
// Usage: samples arrive on s_in (valid/ready); one result per sample leaves on m_out
// (valid/ready) carrying the Q15 dot product of the coefficient registers with the
// last TAPS samples, oldest sample times coef 0. For the first TAPS-1 samples after
// reset the sample itself, shifted left by 15, is returned with warming_up set.
// Coefficients are written through i_cfg_we/i_cfg_idx/i_cfg_data; indexes 8 and above
// are ignored. The user must write them only while the block is idle; the block
// itself does not enforce this. The accepting edge loads the input register; the
// product register and then the sum register load in turn, each when the stage after
// it is empty or moving, and m_out.valid rises when the sum register holds the result.
// Throughput: one beat per clock while m_out.ready is held high, set by the three-stage
// pipeline with one multiplier per tap.
// Reset clears coefficients, history, the warm-up count and all valid flags.
// A stalled receiver holds the output beat; each stage keeps loading while the one
// after it is empty or moving, so the input stops only once every stage is full.
`default_nettype none

module fir_weighted_window_sum_core #(
    parameter int TAPS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire fwws_pkg::t_cfg_idx i_cfg_idx,
    input  wire fwws_pkg::t_coef    i_cfg_data,
    fwws_sample_if.sink             s_in,
    fwws_result_if.source           m_out
);
    import fwws_pkg::*;

    localparam int HIST_D = TAPS - 1;
    localparam int FILL_W = (TAPS > 2) ? $clog2(TAPS) : 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS - 1);

    t_coef             r_coef [NUM_COEFS];
    t_sample           r_hist [HIST_D];
    logic [FILL_W-1:0] r_fill;
    t_sample           r_win  [TAPS];
    logic              r_warm;
    logic              r_v0;
    logic              r_v1;
    logic              r_v2;
    logic              in_acc;
    t_stage_en         en;
    logic              s0_ld;

    // stage load enables, back to front
    always_comb begin
        en.sum_ld  = !r_v2 || m_out.ready;
        en.prod_ld = !r_v1 || en.sum_ld;
        s0_ld      = !r_v0 || en.prod_ld;
    end

    assign s_in.ready = s0_ld;
    assign in_acc     = s_in.valid && s0_ld;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we && !i_cfg_idx[CFG_IDX_W-1]) begin
            r_coef[i_cfg_idx[COEF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // sample history and warm-up count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_D; k++) begin
                r_hist[k] <= '0;
            end
            r_fill <= '0;
        end else if (in_acc) begin
            r_hist[0] <= s_in.sample;
            for (int k = 1; k < HIST_D; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // input register: full window, oldest first
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win[TAPS-1] <= s_in.sample;
            for (int j = 0; j < TAPS - 1; j++) begin
                r_win[j] <= r_hist[TAPS-2-j];
            end
            r_warm <= (r_fill != FILL_FULL);
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s0_ld) begin
                r_v0 <= s_in.valid;
            end
            if (en.prod_ld) begin
                r_v1 <= r_v0;
            end
            if (en.sum_ld) begin
                r_v2 <= r_v1;
            end
        end
    end

    // products and sum
    fwws_dot #(
        .TAPS (TAPS)
    ) u_dot (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_win  (r_win),
        .i_warm (r_warm),
        .i_coef (r_coef),
        .o_sum  (m_out.weighted_sum),
        .o_warm (m_out.warming_up)
    );

    assign m_out.valid = r_v2;

    // checks
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("warm-up count past window length");

    a_full_no_warm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (r_fill == FILL_FULL) |=> !r_warm)
        else $error("warm-up flag set with full window");

    a_prod_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !en.sum_ld |=> r_v1)
        else $error("product stage dropped a stalled beat");

    a_warm_scale : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && m_out.warming_up |-> (m_out.weighted_sum[Q_SHIFT-1:0] == '0))
        else $error("warm-up result not on q15 scale");

endmodule

`default_nettype wire

// ===== tb/fir_weighted_window_sum_core_test.sv =====
// self-checking testbench for the fir weighted window sum core with random gaps and stalls
`timescale 1ns / 1ps

module fir_weighted_window_sum_core_test;
    import fwws_pkg::*;

    localparam int FILTER_TAPS  = 8;
    localparam int HIST_DEPTH   = FILTER_TAPS - 1;
    localparam int RANDOM_BEATS = 1750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    // extreme and corner values shared by samples and coefficients
    localparam logic [15:0] V_MIN = 16'h8000;
    localparam logic [15:0] V_MAX = 16'h7fff;
    localparam logic [15:0] V_NEG1 = 16'hffff;

    typedef struct packed {
        t_sum weighted_sum;
        logic warming_up;
    } window_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_coef i_cfg_data;

    fwws_sample_if sample_ch ();
    fwws_result_if result_ch ();

    fir_weighted_window_sum_core #(
        .TAPS(FILTER_TAPS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_in      (sample_ch),
        .m_out     (result_ch)
    );

    // filter state as the block should hold it
    t_coef coef_model [NUM_COEFS];
    t_sample history_model [HIST_DEPTH];
    int warm_count;

    window_result expected_sums[$];
    t_sample sample_queue[$];
    int samples_queued;
    int samples_accepted;
    int mismatch_count;

    int send_gap;
    int hold_off;
    bit send_burst;
    bit drain_burst;
    int stall_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // wait count before the next beat; occasionally switch between idling and bursts
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 63) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // window dot product or warm-up pass-through for one accepted sample
    function automatic void predict_window_sum(input t_sample s);
        longint acc;
        longint c;
        longint x;
        window_result res;
        x = s;
        if (warm_count < FILTER_TAPS - 1) begin
            acc = x <<< Q_SHIFT;
            res.warming_up = 1'b1;
            warm_count++;
        end else begin
            c = coef_model[FILTER_TAPS-1];
            acc = c * x;
            for (int k = 0; k < FILTER_TAPS - 1; k++) begin
                c = coef_model[FILTER_TAPS-2-k];
                x = history_model[k];
                acc += c * x;
            end
            res.warming_up = 1'b0;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            history_model[k] = history_model[k-1];
        history_model[0] = s;
        res.weighted_sum = acc[SUM_W-1:0];
        expected_sums.push_back(res);
    endfunction

    // sample driver: queued samples go out with random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                predict_window_sum(sample_ch.sample);
                samples_accepted++;
                send_gap = draw_gap(send_burst);
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.sample <= sample_queue.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stalls, every beat compared with the oldest expectation
    always @(posedge i_clk) begin
        window_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_off = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat sum %0d flag %0b",
                        result_ch.weighted_sum, result_ch.warming_up));
                end else begin
                    want = expected_sums.pop_front();
                    if (result_ch.weighted_sum !== want.weighted_sum)
                        report_mismatch($sformatf("weighted_sum got %0d expected %0d",
                            result_ch.weighted_sum, $signed(want.weighted_sum)));
                    if (result_ch.warming_up !== want.warming_up)
                        report_mismatch($sformatf("warming_up got %0b expected %0b",
                            result_ch.warming_up, want.warming_up));
                end
                hold_off = draw_gap(drain_burst);
            end else if (hold_off > 0) begin
                hold_off--;
            end
            result_ch.ready <= (hold_off == 0);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("fir_weighted_window_sum_core_test: errors");
                $finish;
            end
        end
    end

    task automatic queue_sample(input t_sample s);
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // one register write; indexes past the last coefficient leave the model alone
    task automatic write_coef(input t_cfg_idx idx, input t_coef value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx < NUM_COEFS)
            coef_model[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle once every sample is in and every result is out
    task automatic wait_idle();
        while (samples_accepted != samples_queued || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_corner();
        case ($urandom_range(0, 4))
            0: return V_MIN;
            1: return V_MAX;
            2: return V_NEG1;
            3: return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic t_sample draw_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return t_sample'(pick_corner());
        else if (r == 2)
            return t_sample'($urandom_range(0, 127) - 64);
        return t_sample'($urandom());
    endfunction

    // new coefficient set for a phase, plus the odd write to an unused index
    task automatic load_coef_set();
        int mode;
        int tap;
        t_coef value;
        mode = $urandom_range(0, 5);
        tap = $urandom_range(0, NUM_COEFS - 1);
        for (int i = 0; i < NUM_COEFS; i++) begin
            case (mode)
                0: value = t_coef'($urandom());
                1: value = t_coef'(V_MIN);
                2: value = t_coef'(V_MAX);
                3: value = (i == tap) ? t_coef'(16'h4000) : '0;
                4: value = t_coef'(pick_corner());
                default: value = t_coef'($urandom());
            endcase
            // partial update keeps some coefficients from the last phase
            if (mode != 5 || $urandom_range(0, 1) == 1)
                write_coef(t_cfg_idx'(i), value);
        end
        if ($urandom_range(0, 2) == 0)
            write_coef(t_cfg_idx'($urandom_range(NUM_COEFS, 2 ** CFG_IDX_W - 1)),
                t_coef'($urandom()));
    endtask

    // stimulus
    initial begin
        int remaining;
        int phase_len;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready = 1'b0;
        send_burst = 1'b0;
        drain_burst = 1'b0;
        stall_cycles = 0;
        samples_queued = 0;
        samples_accepted = 0;
        mismatch_count = 0;
        warm_count = 0;
        foreach (coef_model[i])
            coef_model[i] = '0;
        foreach (history_model[i])
            history_model[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // warm-up pass-through with extreme samples, then one full window of zero weights
        queue_sample(t_sample'(V_MIN));
        queue_sample(t_sample'(V_MAX));
        queue_sample('0);
        queue_sample(t_sample'(V_NEG1));
        queue_sample(t_sample'(16'h0001));
        queue_sample(t_sample'(16'h5555));
        queue_sample(t_sample'(16'haaaa));
        queue_sample(t_sample'(16'd12345));
        wait_idle();

        // largest positive sum, then largest negative; unused indexes must be ignored
        for (int i = 0; i < NUM_COEFS; i++)
            write_coef(t_cfg_idx'(i), t_coef'(V_MIN));
        for (int i = NUM_COEFS; i < 2 ** CFG_IDX_W; i++)
            write_coef(t_cfg_idx'(i), t_coef'(V_MAX));
        repeat (FILTER_TAPS) queue_sample(t_sample'(V_MIN));
        repeat (FILTER_TAPS) queue_sample(t_sample'(V_MAX));
        wait_idle();

        // random phases, each with its own coefficient set
        remaining = RANDOM_BEATS;
        while (remaining > 0) begin
            load_coef_set();
            phase_len = $urandom_range(20, 200);
            if (phase_len > remaining)
                phase_len = remaining;
            repeat (phase_len) queue_sample(draw_sample());
            remaining -= phase_len;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_sums.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
        if (mismatch_count == 0)
            $display("fir_weighted_window_sum_core_test: clean");
        else
            $display("fir_weighted_window_sum_core_test: errors");
        $finish;
    end

endmodule
